>>> rtl/cbd_pkg.sv
// Shared constants, codes, types and ring index helpers for the circular buffer deque.
`timescale 1ns / 1ps

package cbd_pkg;

	localparam int DEPTH   = 16;
	localparam int VALUE_W = 32;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP_W   = 5;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;

	localparam int IN_BITS  = OP_W + VALUE_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STAT_W + 2 * VALUE_W + 2;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CAP_W-1:0]   cap_t;
	typedef logic [VALUE_W-1:0] value_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK       = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Write port of the ring store
	typedef struct packed {
		logic   en;
		idx_t   addr;
		value_t data;
	} ram_wr_t;

	// Read addresses for the front and back slots
	typedef struct packed {
		idx_t front_addr;
		idx_t back_addr;
	} ram_rd_t;

	// Clamp the capacity register into 1..DEPTH
	function automatic cap_t clamp_cap(input cap_t c);
		cap_t r;
		r = c;
		if (c == '0)
			r = CAP_W'(1);
		if (c > CAP_W'(DEPTH))
			r = CAP_W'(DEPTH);
		return r;
	endfunction

	function automatic idx_t ring_next(input idx_t i, input cap_t cap);
		cap_t n;
		n = CAP_W'(i) + CAP_W'(1);
		return (n >= cap) ? '0 : IDX_W'(n);
	endfunction

	function automatic idx_t ring_prev(input idx_t i, input cap_t cap);
		cap_t p;
		p = cap - CAP_W'(1);
		return (i == '0 || CAP_W'(i) >= cap) ? IDX_W'(p) : i - IDX_W'(1);
	endfunction

endpackage

>>> rtl/cbd_ring_ram.sv
// Ring store: one write port and two registered read ports.
`timescale 1ns / 1ps

module cbd_ring_ram (
	input  logic             clk,
	input  cbd_pkg::ram_wr_t wr,
	input  cbd_pkg::ram_rd_t rd,
	output cbd_pkg::value_t  front_data,
	output cbd_pkg::value_t  back_data
);

	cbd_pkg::value_t mem [cbd_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		front_data <= mem[rd.front_addr];
		back_data  <= mem[rd.back_addr];
	end

endmodule

>>> rtl/circular_buffer_deque.sv
// Top level of the circular buffer deque: operation sequencer, pointers and output register.
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit values kept in a 16-slot ring memory.
// Each input transfer carries one operation (push front/back, pop front/back,
// peek; unused codes act as peek) and yields exactly one result transfer
// with the status, the front and back values after the operation (all ones,
// i.e. -1, when empty) and the empty and full flags. A push onto a full
// deque returns overflow, a pop from an empty one underflow; neither changes
// the contents. Each operation passes through S_IDLE, S_READ and S_DONE: the
// pointers are updated and any pushed value written in the accept cycle, the
// front and back slots are read on the next cycle, and the registered read
// data forms the result in S_DONE; a result waiting in the output register
// holds the sequencer there. The capacity register (1..16, zero taken as 1,
// larger values as 16) is written through the cfg channel while the block is
// idle; every write empties the deque. The store needs no clearing after reset.
module circular_buffer_deque (
	input  logic                       clk,
	input  logic                       arst_n,
	// Capacity write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cbd_pkg::CAP_W-1:0]  cfg_data,
	// Operations in
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// [2:0] operation, [34:3] push_value, [39:35] zero
	input  logic [cbd_pkg::IN_W-1:0]   s_axis_tdata,
	// Results out
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [1:0] status, [33:2] front_value, [65:34] back_value,
	// [66] is_empty, [67] is_full, [71:68] zero
	output logic [cbd_pkg::OUT_W-1:0]  m_axis_tdata
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_DONE = 3'b100
	} seq_state_t;

	seq_state_t        state_q;
	cbd_pkg::idx_t     head_q, tail_q;
	logic              empty_q;
	cbd_pkg::cap_t     cap_q;
	cbd_pkg::status_t  status_q;
	logic              out_valid_q;
	logic [cbd_pkg::OUT_BITS-1:0] out_data_q;

	cbd_pkg::cap_t     cap;
	logic              in_xfer, cfg_xfer, out_load;
	cbd_pkg::op_t      op;
	cbd_pkg::value_t   push_val;
	cbd_pkg::idx_t     head_d, tail_d;
	logic              empty_d;
	cbd_pkg::status_t  status_d;
	cbd_pkg::ram_wr_t  wr;
	cbd_pkg::ram_rd_t  rd;
	cbd_pkg::value_t   front_rd, back_rd;
	logic              full_now;

	assign cap      = cbd_pkg::clamp_cap(cap_q);
	assign op       = cbd_pkg::op_t'(s_axis_tdata[cbd_pkg::OP_W-1:0]);
	assign push_val = s_axis_tdata[cbd_pkg::OP_W +: cbd_pkg::VALUE_W];

	// Configuration wins over an operation offered in the same idle cycle
	assign cfg_ready     = (state_q == S_IDLE);
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_xfer      = cfg_valid && cfg_ready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Full test on the pointers as they stand
	assign full_now = !empty_q && (cbd_pkg::ring_next(tail_q, cap) == head_q);

	// Pointer update and store write for the offered operation
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		empty_d  = empty_q;
		status_d = cbd_pkg::ST_DONE;
		wr.en    = 1'b0;
		wr.addr  = '0;
		wr.data  = push_val;
		unique case (op)
			cbd_pkg::OP_PUSH_FRONT, cbd_pkg::OP_PUSH_BACK: begin
				priority if (empty_q) begin
					// first element always lands in slot zero
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
					wr.en   = 1'b1;
					wr.addr = '0;
				end else if (full_now) begin
					status_d = cbd_pkg::ST_OVERFLOW;
				end else if (op == cbd_pkg::OP_PUSH_FRONT) begin
					head_d  = cbd_pkg::ring_prev(head_q, cap);
					wr.en   = 1'b1;
					wr.addr = head_d;
				end else begin
					tail_d  = cbd_pkg::ring_next(tail_q, cap);
					wr.en   = 1'b1;
					wr.addr = tail_d;
				end
			end
			cbd_pkg::OP_POP_FRONT, cbd_pkg::OP_POP_BACK: begin
				priority if (empty_q) begin
					status_d = cbd_pkg::ST_UNDERFLOW;
				end else if (head_q == tail_q) begin
					// last element gone from either end
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b1;
				end else if (op == cbd_pkg::OP_POP_FRONT) begin
					head_d = cbd_pkg::ring_next(head_q, cap);
				end else begin
					tail_d = cbd_pkg::ring_prev(tail_q, cap);
				end
			end
			default: begin
				// peek and unused codes leave the deque alone
			end
		endcase
		wr.en = wr.en && in_xfer;
	end

	// Read the updated front and back slots in the step after the write
	assign rd.front_addr = head_q;
	assign rd.back_addr  = tail_q;

	cbd_ring_ram u_ram (
		.clk        (clk),
		.wr         (wr),
		.rd         (rd),
		.front_data (front_rd),
		.back_data  (back_rd)
	);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			cap_q       <= cbd_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_xfer) begin
						// new capacity: drop all contents
						cap_q   <= cfg_data;
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b1;
					end else if (in_xfer) begin
						head_q  <= head_d;
						tail_q  <= tail_d;
						empty_q <= empty_d;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			status_q <= status_d;
		end
		if (out_load) begin
			out_data_q <= {full_now,
			               empty_q,
			               empty_q ? {cbd_pkg::VALUE_W{1'b1}} : back_rd,
			               empty_q ? {cbd_pkg::VALUE_W{1'b1}} : front_rd,
			               status_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(cbd_pkg::OUT_W - cbd_pkg::OUT_BITS){1'b0}}, out_data_q};

endmodule
